// ----- rtl/wtc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wtc_pkg: shared types and constants of the window threshold classifier
// Register indexes, class codes, default sizes and the control structs that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package wtc_pkg;

   // Default sizing
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_RADIUS = 4;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int GRID_W_W   = 11;
   localparam int RADIUS_W   = 3;
   localparam int RELAX_W    = 7;
   localparam int SAMPLE_W   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_BOUND       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_BOUND      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_RADIUS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RELAX_COUNT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_OVERRIDE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_BAD_CODE        = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MISSING_CODE    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH      = 3'd7;

   // Result classes
   localparam logic [1:0] CLASS_FALSE   = 2'd0;
   localparam logic [1:0] CLASS_RELAXED = 2'd1;
   localparam logic [1:0] CLASS_TRUE    = 2'd2;
   localparam logic [1:0] CLASS_MISSING = 2'd3;

   // Input commands
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_FIN
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic restart;
      logic write_sample;
      logic set_drain;
      logic scan_start;
      logic scan_step;
      logic finish;
      logic load_rsp;
      logic last;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic draining;
      logic pend_zero;
      logic pend_one;
      logic emit_new;
      logic scan_last;
   } dp_status_type;

endpackage
`default_nettype wire

// ----- rtl/wtc_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wtc_ram: generic simple dual port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module wtc_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

// ----- rtl/wtc_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wtc_ctrl: sequencing of one item
// Decides per transfer whether a result is due, steps the window scan and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module wtc_ctrl
   import wtc_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_cmd,
   input  wire logic          req_frame_end,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // State and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.last  = last_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.draining && status.pend_zero) begin
                  cmd.restart = 1'b1;
               end else if (req_cmd == CMD_SAMPLE && !status.draining) begin
                  cmd.write_sample = 1'b1;
                  cmd.set_drain    = req_frame_end &&
                                     !(status.emit_new && status.pend_zero);
                  if (status.emit_new) begin
                     cmd.scan_start = 1'b1;
                     last_in        = req_frame_end && status.pend_zero;
                     state_in       = ST_SCAN;
                  end
               end else if (status.draining) begin
                  cmd.scan_start = 1'b1;
                  last_in        = status.pend_one;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               cmd.finish   = 1'b1;
               cmd.restart  = last_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set on load, drop on transfer
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- rtl/wtc_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wtc_datapath: line store, position counters and window scan
// Writes one flag pair per sample into a ring of rows, then scans the
// window one position per cycle and counts in-limit and missing positions.
// ----------------------------------------------------------------------------
module wtc_datapath
   import wtc_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ctrl_cmd_type               cmd,
   output dp_status_type                   status,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic signed [SAMPLE_W-1:0] low_bound,
   input  wire logic signed [SAMPLE_W-1:0] high_bound,
   input  wire logic [RADIUS_W-1:0]        window_radius,
   input  wire logic [RELAX_W-1:0]         relax_count,
   input  wire logic                       center_override,
   input  wire logic signed [SAMPLE_W-1:0] bad_code,
   input  wire logic signed [SAMPLE_W-1:0] missing_code,
   input  wire logic [GRID_W_W-1:0]        grid_width,
   output logic [1:0]                      rsp_class_code,
   output logic                            rsp_frame_last
);

   localparam int RING  = 2 * MAX_RADIUS + 2;
   localparam int DEPTH = RING * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int RW    = $clog2(MAX_RADIUS + 1);
   localparam int DW    = $clog2(2 * MAX_RADIUS + 1);
   localparam int PW    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 2);
   localparam int XW    = PW + 1;
   localparam int NW    = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
   localparam int KW    = (NW > RELAX_W) ? NW : RELAX_W;
   localparam int GW    = (WW > GRID_W_W) ? WW : GRID_W_W;
   localparam int QW    = (RW > RADIUS_W) ? RW : RADIUS_W;
   localparam int LW    = CW + 2;
   localparam logic [AW-1:0] LAST_BASE = AW'(DEPTH - MAX_WIDTH);
   localparam logic [AW-1:0] ROW_STEP  = AW'(MAX_WIDTH);

   // Effective width and radius
   logic [GW-1:0] gw_ext;
   logic [WW-1:0] w_eff;
   logic [QW-1:0] rad_ext;
   logic [RW-1:0] r_eff;
   logic [PW-1:0] lag;
   logic [NW-1:0] win_size;
   logic [AW-1:0] back_ofs;

   assign gw_ext  = GW'(grid_width);
   assign rad_ext = QW'(window_radius);

   always_comb begin
      if (gw_ext == '0) begin
         w_eff = WW'(1);
      end else if (gw_ext > GW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(gw_ext);
      end
      if (rad_ext > QW'(MAX_RADIUS)) begin
         r_eff = RW'(MAX_RADIUS);
      end else begin
         r_eff = RW'(rad_ext);
      end
   end

   assign lag      = (PW'(r_eff) * PW'(w_eff)) + PW'(r_eff);
   assign win_size = NW'({r_eff, 1'b1}) * NW'({r_eff, 1'b1});
   assign back_ofs = AW'(r_eff) * ROW_STEP;

   // Position and scan registers
   logic [CW-1:0] in_col_ff, in_col_in;
   logic [AW-1:0] in_base_ff, in_base_in;
   logic [CW-1:0] out_col_ff, out_col_in;
   logic [AW-1:0] out_base_ff, out_base_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic [PW-1:0] pend_ff, pend_in;
   logic          drain_ff, drain_in;
   logic          center_ff, center_in;
   logic [DW-1:0] dri_ff, dri_in;
   logic [DW-1:0] dci_ff, dci_in;
   logic [XW-1:0] rowidx_ff, rowidx_in;
   logic [AW-1:0] rb_ff, rb_in;
   logic [NW-1:0] found_ff, found_in;
   logic [NW-1:0] miss_ff, miss_in;
   logic          ovr_ff, ovr_in;
   logic          p_valid_ff, p_center_ff, p_inr_ff;
   logic          p_valid_in, p_center_in, p_inr_in;
   logic [1:0]    class_ff, class_in;
   logic          flast_ff, flast_in;

   // Line store port signals
   logic [AW-1:0] wr_addr, rd_addr;
   logic [1:0]    wr_data, rd_data;

   // Sample flags
   logic is_code, in_lim;
   assign is_code = (req_sample == bad_code) || (req_sample == missing_code);
   assign in_lim  = (req_sample >= low_bound) && (req_sample <= high_bound);
   assign wr_data = {in_lim, is_code};
   assign wr_addr = in_base_ff + AW'(in_col_ff);

   // Window position checks
   logic [DW:0]   row_sum;
   logic [LW-1:0] col_sum;
   logic [XW-1:0] idx, idx_lim;
   logic          row_ok, col_ok, idx_ok, inr;
   logic [CW-1:0] win_col;
   logic          dci_end, dri_end;
   logic [AW:0]   start_base;

   assign row_sum = (DW+1)'(dri_ff) + (DW+1)'(out_row_ff);
   assign row_ok  = row_sum >= (DW+1)'(r_eff);
   assign col_sum = LW'(out_col_ff) + LW'(dci_ff);
   assign col_ok  = (col_sum >= LW'(r_eff)) && (col_sum < (LW'(w_eff) + LW'(r_eff)));
   assign idx     = rowidx_ff + XW'(dci_ff);
   assign idx_lim = XW'(pend_ff) + XW'(lag);
   assign idx_ok  = idx < idx_lim;
   assign inr     = row_ok && col_ok && idx_ok;
   assign win_col = CW'(col_sum - LW'(r_eff));
   assign dci_end = dci_ff == DW'({r_eff, 1'b0});
   assign dri_end = dri_ff == DW'({r_eff, 1'b0});

   always_comb begin
      if (out_base_ff >= back_ofs) begin
         start_base = (AW+1)'(out_base_ff) - (AW+1)'(back_ofs);
      end else begin
         start_base = (AW+1)'(out_base_ff) + (AW+1)'(DEPTH) - (AW+1)'(back_ofs);
      end
   end

   assign rd_addr = center_ff ? (out_base_ff + AW'(out_col_ff)) : (rb_ff + AW'(win_col));

   // Class from the finished counts
   logic [1:0] cls;
   always_comb begin
      cls = CLASS_FALSE;
      if (found_ff == win_size) begin
         cls = CLASS_TRUE;
      end else if (KW'(found_ff) >= KW'(relax_count)) begin
         cls = CLASS_RELAXED;
      end
      if (miss_ff == win_size) begin
         cls = CLASS_MISSING;
      end
      if (center_override && ovr_ff) begin
         cls = CLASS_TRUE;
      end
   end

   // Next values
   always_comb begin
      in_col_in   = in_col_ff;
      in_base_in  = in_base_ff;
      out_col_in  = out_col_ff;
      out_base_in = out_base_ff;
      out_row_in  = out_row_ff;
      pend_in     = pend_ff;
      drain_in    = drain_ff;
      center_in   = center_ff;
      dri_in      = dri_ff;
      dci_in      = dci_ff;
      rowidx_in   = rowidx_ff;
      rb_in       = rb_ff;
      found_in    = found_ff;
      miss_in     = miss_ff;
      ovr_in      = ovr_ff;
      p_valid_in  = cmd.scan_step;
      p_center_in = center_ff;
      p_inr_in    = inr;
      class_in    = class_ff;
      flast_in    = flast_ff;

      // Store a sample and advance the write position
      if (cmd.write_sample) begin
         pend_in = pend_ff + PW'(1);
         if ((WW'(in_col_ff) + WW'(1)) >= w_eff) begin
            in_col_in  = '0;
            in_base_in = (in_base_ff == LAST_BASE) ? '0 : in_base_ff + ROW_STEP;
         end else begin
            in_col_in = in_col_ff + CW'(1);
         end
      end
      if (cmd.set_drain) begin
         drain_in = 1'b1;
      end

      // Start the scan at the window's top left
      if (cmd.scan_start) begin
         center_in = 1'b1;
         dri_in    = '0;
         dci_in    = '0;
         rowidx_in = '0;
         rb_in     = AW'(start_base);
         found_in  = '0;
         miss_in   = '0;
         ovr_in    = 1'b0;
      end

      // Advance one window position
      if (cmd.scan_step) begin
         if (center_ff) begin
            center_in = 1'b0;
         end else if (dci_end) begin
            dci_in    = '0;
            dri_in    = dri_ff + DW'(1);
            rowidx_in = rowidx_ff + XW'(w_eff);
            rb_in     = (rb_ff == LAST_BASE) ? '0 : rb_ff + ROW_STEP;
         end else begin
            dci_in = dci_ff + DW'(1);
         end
      end

      // Count the entry read last cycle
      if (p_valid_ff) begin
         if (p_center_ff) begin
            ovr_in = rd_data[1];
         end else if (!p_inr_ff || rd_data[0]) begin
            miss_in = miss_ff + NW'(1);
         end else if (rd_data[1]) begin
            found_in = found_ff + NW'(1);
         end
      end

      // Retire the point and load the result
      if (cmd.load_rsp) begin
         class_in = cls;
         flast_in = cmd.last;
      end
      if (cmd.finish) begin
         pend_in = pend_ff - PW'(1);
         if (out_row_ff != RW'(MAX_RADIUS) && (WW'(out_col_ff) + WW'(1)) >= w_eff) begin
            out_row_in = out_row_ff + RW'(1);
         end
         if ((WW'(out_col_ff) + WW'(1)) >= w_eff) begin
            out_col_in  = '0;
            out_base_in = (out_base_ff == LAST_BASE) ? '0 : out_base_ff + ROW_STEP;
         end else begin
            out_col_in = out_col_ff + CW'(1);
         end
      end

      // Plane restart wins over the updates above
      if (cmd.restart) begin
         in_col_in   = '0;
         in_base_in  = '0;
         out_col_in  = '0;
         out_base_in = '0;
         out_row_in  = '0;
         pend_in     = '0;
         drain_in    = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_base_ff  <= '0;
         out_col_ff  <= '0;
         out_base_ff <= '0;
         out_row_ff  <= '0;
         pend_ff     <= '0;
         drain_ff    <= 1'b0;
         center_ff   <= 1'b0;
         dri_ff      <= '0;
         dci_ff      <= '0;
         p_valid_ff  <= 1'b0;
      end else begin
         in_col_ff   <= in_col_in;
         in_base_ff  <= in_base_in;
         out_col_ff  <= out_col_in;
         out_base_ff <= out_base_in;
         out_row_ff  <= out_row_in;
         pend_ff     <= pend_in;
         drain_ff    <= drain_in;
         center_ff   <= center_in;
         dri_ff      <= dri_in;
         dci_ff      <= dci_in;
         p_valid_ff  <= p_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rowidx_ff   <= rowidx_in;
      rb_ff       <= rb_in;
      found_ff    <= found_in;
      miss_ff     <= miss_in;
      ovr_ff      <= ovr_in;
      p_center_ff <= p_center_in;
      p_inr_ff    <= p_inr_in;
      class_ff    <= class_in;
      flast_ff    <= flast_in;
   end

   wtc_ram #(
      .WIDTH (2),
      .DEPTH (DEPTH)
   ) u_line_store (
      .clock      (clock),
      .wr_en      (cmd.write_sample),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   // Status
   assign status.draining  = drain_ff;
   assign status.pend_zero = pend_ff == '0;
   assign status.pend_one  = pend_ff == PW'(1);
   assign status.emit_new  = ((PW+1)'(pend_ff) + (PW+1)'(1)) > (PW+1)'(lag);
   assign status.scan_last = !center_ff && dci_end && dri_end;

   assign rsp_class_code = class_ff;
   assign rsp_frame_last = flast_ff;

endmodule
`default_nettype wire

// ----- rtl/window_threshold_classifier_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// window_threshold_classifier_top: window threshold classifier
// Classifies raster grid points by the in-limit and missing counts of the
// square window around them, with a line store of recent rows.
// ----------------------------------------------------------------------------
// Result: a result is loaded after the transfer that produces it once the scan has read
//    the center entry and then each window position, and the output is free to take it.
// Throughput: while a result is due, the input is held off until the result is loaded;
//    one item per cycle otherwise. The single read port of the line store sets this.
// Reset: synchronous; clears control counters, flags, state and configuration; payload
//    registers and line store contents are not cleared and need no clearing pass.
module window_threshold_classifier_top
   import wtc_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_cmd,
   input  wire logic signed [SAMPLE_W-1:0]  req_sample,
   input  wire logic                        req_frame_end,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [1:0]                       rsp_class_code,
   output logic                             rsp_frame_last,
   input  wire logic                        csr_we,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]       csr_wdata
);

   logic signed [SAMPLE_W-1:0] lower_ff, upper_ff, bad_ff, missing_ff;
   logic [RADIUS_W-1:0]        radius_ff;
   logic [RELAX_W-1:0]         relax_ff;
   logic                       override_ff;
   logic [GRID_W_W-1:0]        width_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff    <= 16'sd0;
         upper_ff    <= 16'sd32767;
         radius_ff   <= '0;
         relax_ff    <= RELAX_W'(1);
         override_ff <= 1'b0;
         bad_ff      <= 16'sh8000;
         missing_ff  <= 16'sh8001;
         width_ff    <= GRID_W_W'(1024);
      end else if (csr_we) begin
         case (csr_index)
            CSR_LOW_BOUND:       lower_ff    <= csr_wdata;
            CSR_HIGH_BOUND:      upper_ff    <= csr_wdata;
            CSR_WINDOW_RADIUS:   radius_ff   <= csr_wdata[RADIUS_W-1:0];
            CSR_RELAX_COUNT:     relax_ff    <= csr_wdata[RELAX_W-1:0];
            CSR_CENTER_OVERRIDE: override_ff <= csr_wdata[0];
            CSR_BAD_CODE:        bad_ff      <= csr_wdata;
            CSR_MISSING_CODE:    missing_ff  <= csr_wdata;
            CSR_GRID_WIDTH:      width_ff    <= csr_wdata[GRID_W_W-1:0];
            default: begin
            end
         endcase
      end
   end

   ctrl_cmd_type  cmd;
   dp_status_type status;

   wtc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_cmd       (req_cmd),
      .req_frame_end (req_frame_end),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   wtc_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_RADIUS (MAX_RADIUS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_sample      (req_sample),
      .low_bound       (lower_ff),
      .high_bound      (upper_ff),
      .window_radius   (radius_ff),
      .relax_count     (relax_ff),
      .center_override (override_ff),
      .bad_code        (bad_ff),
      .missing_code    (missing_ff),
      .grid_width      (width_ff),
      .rsp_class_code  (rsp_class_code),
      .rsp_frame_last  (rsp_frame_last)
   );

endmodule
`default_nettype wire

// ----- rtl/wtc_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// wtc_checker: port level checks of the window threshold classifier
// Watches the handshake and result timing on the top level ports.
// ----------------------------------------------------------------------------
module wtc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_class_code,
   input wire logic       rsp_frame_last
);

   // Hold a stalled result
   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_class_code) &&
                                        $stable(rsp_frame_last));
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result changed while stalled");

   // No result right after reset
   property p_rsp_after_reset;
      @(posedge clock) reset |=> !rsp_valid;
   endproperty
   a_rsp_after_reset: assert property (p_rsp_after_reset)
      else $error("result valid after reset");

   // A new result is loaded only while input is held off
   property p_rsp_busy;
      @(posedge clock) disable iff (reset)
         $rose(rsp_valid) |-> !$past(req_ready);
   endproperty
   a_rsp_busy: assert property (p_rsp_busy)
      else $error("result loaded while input was open");

endmodule

bind window_threshold_classifier_top wtc_checker u_wtc_checker (.*);
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the window threshold classifier
// Streams raster planes through the block, predicts the class of every point
// from the window around it, and checks each result transfer in order.
// ----------------------------------------------------------------------------
module tb;
   import wtc_pkg::*;

   localparam int RING    = 2 * DEF_MAX_RADIUS + 2;
   localparam int SETTLE  = 100;
   localparam int ITEMS   = 1000;

   typedef struct packed {
      logic [1:0] cls;
      logic       last;
   } point_result_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_cmd = CMD_SAMPLE;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_frame_end = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [1:0]                 rsp_class_code;
   logic                       rsp_frame_last;
   logic                       csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]       csr_index = CSR_LOW_BOUND;
   logic [CSR_DATA_W-1:0]      csr_wdata = '0;

   // predictor copy of the registers
   logic signed [15:0] lo_lim, hi_lim, bad_val, miss_val;
   logic [2:0]         rad_reg;
   logic [6:0]         relax_reg;
   logic               ovr_reg;
   logic [10:0]        wid_reg;

   // predictor copy of the state
   logic [1:0] row_store [0:RING*DEF_MAX_WIDTH-1];
   int         wr_col, wr_row, rd_col, rd_row, rd_slot, backlog;
   bit         drain_on;

   point_result_type class_q[$];
   int               mismatches = 0;
   int               items_sent = 0;
   int               hold_left = 0;
   bit               quiet = 1'b0;

   window_threshold_classifier_top u_top (.*);

   always #2 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic void plane_restart();
      wr_col = 0; wr_row = 0; rd_col = 0; rd_row = 0; rd_slot = 0;
      backlog = 0; drain_on = 1'b0;
   endfunction

   function automatic void model_reset();
      foreach (row_store[i]) row_store[i] = 2'b00;
      plane_restart();
      lo_lim = 16'sd0; hi_lim = 16'sd32767; rad_reg = '0; relax_reg = 7'd1;
      ovr_reg = 1'b0; bad_val = 16'h8000; miss_val = 16'h8001; wid_reg = 11'd1024;
   endfunction

   function automatic void model_write(logic [CSR_IDX_W-1:0] idx, logic [15:0] d);
      case (idx)
         CSR_LOW_BOUND:       lo_lim = d;
         CSR_HIGH_BOUND:      hi_lim = d;
         CSR_WINDOW_RADIUS:   rad_reg = d[2:0];
         CSR_RELAX_COUNT:     relax_reg = d[6:0];
         CSR_CENTER_OVERRIDE: ovr_reg = d[0];
         CSR_BAD_CODE:        bad_val = d;
         CSR_MISSING_CODE:    miss_val = d;
         CSR_GRID_WIDTH:      wid_reg = d[10:0];
         default:             ;
      endcase
   endfunction

   // count found and missing positions of the window around the output point
   function automatic logic [1:0] window_class(int w, int r);
      int found, miss, size, col, off, slot;
      logic [1:0] ent, c;
      found = 0; miss = 0; size = (2 * r + 1) * (2 * r + 1);
      for (int dr = -r; dr <= r; dr++) begin
         for (int dc = -r; dc <= r; dc++) begin
            col = rd_col + dc;
            off = dr * w + dc;
            if (rd_row + dr < 0 || col < 0 || col >= w || off >= backlog) begin
               miss++;
            end else begin
               slot = (rd_slot + dr + RING) % RING;
               ent = row_store[slot * DEF_MAX_WIDTH + col];
               if (ent[0]) miss++;
               else if (ent[1]) found++;
            end
         end
      end
      c = CLASS_FALSE;
      if (found == size) c = CLASS_TRUE;
      else if (found >= int'(relax_reg)) c = CLASS_RELAXED;
      if (miss == size) c = CLASS_MISSING;
      if (ovr_reg && row_store[rd_slot * DEF_MAX_WIDTH + rd_col][1]) c = CLASS_TRUE;
      return c;
   endfunction

   function automatic void advance_point(int w);
      rd_col++;
      if (rd_col >= w) begin
         rd_col = 0;
         rd_slot = (rd_slot + 1) % RING;
         if (rd_row < 65535) rd_row++;
      end
   endfunction

   function automatic void predict_item(logic cmd, logic signed [15:0] s, logic fe);
      int w, r, lag;
      bit emit;
      logic [1:0] c;
      w = (wid_reg < 1) ? 1 : (wid_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(wid_reg);
      r = (rad_reg > DEF_MAX_RADIUS) ? DEF_MAX_RADIUS : int'(rad_reg);
      lag = r * w + r;
      if (drain_on && backlog == 0) begin
         plane_restart();
         return;
      end
      if (cmd == CMD_SAMPLE && !drain_on) begin
         row_store[wr_row * DEF_MAX_WIDTH + wr_col] =
            {(s >= lo_lim && s <= hi_lim), (s == bad_val || s == miss_val)};
         wr_col++;
         if (wr_col >= w) begin
            wr_col = 0;
            wr_row = (wr_row + 1) % RING;
         end
         backlog++;
         emit = backlog > lag;
         c = CLASS_FALSE;
         if (emit) begin
            c = window_class(w, r);
            backlog--;
            advance_point(w);
         end
         if (fe) begin
            if (backlog == 0) begin
               plane_restart();
               class_q.push_back('{c, 1'b1});
               return;
            end
            drain_on = 1'b1;
         end
         if (emit) class_q.push_back('{c, 1'b0});
         return;
      end
      if (drain_on) begin
         c = window_class(w, r);
         backlog--;
         advance_point(w);
         if (backlog == 0) begin
            plane_restart();
            class_q.push_back('{c, 1'b1});
         end else begin
            class_q.push_back('{c, 1'b0});
         end
      end
   endfunction

   // ---------------------------------------------------------------- receiver
   // hold off for a requested stretch, otherwise stall at random
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= 38);
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      point_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (class_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result class=%0d last=%0b", rsp_class_code,
                        rsp_frame_last);
         end else begin
            want = class_q.pop_front();
            if (want.cls !== rsp_class_code || want.last !== rsp_frame_last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected class=%0d last=%0b, got class=%0d last=%0b",
                           want.cls, want.last, rsp_class_code, rsp_frame_last);
            end
         end
      end
   end

   // ---------------------------------------------------------------- sender
   task automatic send_item(logic cmd, logic signed [15:0] s, logic fe);
      int gap;
      gap = (!quiet && $urandom_range(99) < 38) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_sample <= s;
      req_frame_end <= fe;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(cmd, s, fe);
      items_sent++;
   endtask

   // drop valid, drain every expected result, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (class_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [15:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      @(posedge clock);
      model_write(idx, d);
   endtask

   task automatic configure(logic [15:0] lo, logic [15:0] hi, logic [2:0] r,
                            logic [6:0] relax, logic ovr, logic [15:0] bad,
                            logic [15:0] miss, logic [10:0] w);
      write_reg(CSR_LOW_BOUND, lo);
      write_reg(CSR_HIGH_BOUND, hi);
      write_reg(CSR_WINDOW_RADIUS, {13'd0, r});
      write_reg(CSR_RELAX_COUNT, {9'd0, relax});
      write_reg(CSR_CENTER_OVERRIDE, {15'd0, ovr});
      write_reg(CSR_BAD_CODE, bad);
      write_reg(CSR_MISSING_CODE, miss);
      write_reg(CSR_GRID_WIDTH, {5'd0, w});
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // codes, limit edges and random values in the mix the caller asks for
   function automatic logic [15:0] pick_sample(int code_pct);
      int p;
      p = $urandom_range(99);
      if (p < code_pct) return $urandom_range(1) ? bad_val : miss_val;
      if (p < code_pct + 10) return $urandom_range(1) ? lo_lim : hi_lim;
      if (p < code_pct + 15) return lo_lim - 16'sd1;
      if (p < code_pct + 20) return hi_lim + 16'sd1;
      if (p < code_pct + 30) return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      return 16'($urandom_range(16'hFFFF));
   endfunction

   // send a plane of n samples, then drain it with flushes and stray samples
   task automatic run_plane(int n, int code_pct);
      for (int i = 0; i < n; i++) send_item(CMD_SAMPLE, pick_sample(code_pct), i == n - 1);
      while (drain_on) begin
         if ($urandom_range(99) < 15)
            send_item(CMD_SAMPLE, pick_sample(code_pct), 1'($urandom_range(1)));
         else
            send_item(CMD_FLUSH, 16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
      end
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_reset_defaults();
      send_item(CMD_SAMPLE, 16'sh8000, 1'b0);
      send_item(CMD_SAMPLE, 16'sh8001, 1'b0);
      send_item(CMD_SAMPLE, 16'sh7FFF, 1'b0);
      send_item(CMD_SAMPLE, 16'sh0000, 1'b0);
      send_item(CMD_SAMPLE, 16'shFFFF, 1'b1);
      wait_idle();
   endtask

   task automatic test_codes_and_override();
      configure(16'h8000, 16'h8001, 3'd1, 7'd3, 1'b1, 16'h8000, 16'h8001, 11'd3);
      send_item(CMD_SAMPLE, 16'sh8000, 1'b0);
      send_item(CMD_SAMPLE, 16'sh8001, 1'b0);
      send_item(CMD_SAMPLE, 16'sh8002, 1'b0);
      send_item(CMD_SAMPLE, 16'sh7FFF, 1'b0);
      send_item(CMD_SAMPLE, 16'sh8000, 1'b0);
      send_item(CMD_SAMPLE, 16'sh8001, 1'b0);
      send_item(CMD_SAMPLE, 16'sh8000, 1'b1);
      while (drain_on) send_item(CMD_FLUSH, 16'sh0000, 1'b0);
      wait_idle();
   endtask

   // a flush outside a plane and a frame end on a flush are both ignored
   task automatic test_stray_items();
      configure(16'hFF00, 16'h0100, 3'd1, 7'd0, 1'b0, 16'h1234, 16'h4321, 11'd2);
      send_item(CMD_FLUSH, 16'sh7FFF, 1'b0);
      send_item(CMD_FLUSH, 16'sh8000, 1'b1);
      send_item(CMD_SAMPLE, 16'sh0000, 1'b0);
      send_item(CMD_SAMPLE, 16'sh1234, 1'b0);
      send_item(CMD_SAMPLE, 16'sh0100, 1'b1);
      send_item(CMD_SAMPLE, 16'sh4321, 1'b1);
      while (drain_on) send_item(CMD_FLUSH, 16'sh0000, 1'b1);
      wait_idle();
   endtask

   // out-of-range radius and width clamp to the maximum sizes, and a zero width to one
   task automatic test_clamped_sizes();
      configure(16'h8000, 16'h7FFF, 3'd7, 7'd127, 1'b0, 16'h0000, 16'h0001, 11'd3);
      run_plane(14, 10);
      wait_idle();
      configure(16'h0000, 16'h7FFF, 3'd0, 7'd81, 1'b1, 16'h8000, 16'h8001, 11'd2047);
      run_plane(6, 10);
      wait_idle();
      configure(16'h0000, 16'h7FFF, 3'd1, 7'd1, 1'b0, 16'h8000, 16'h8001, 11'd1024);
      run_plane(20, 10);
      wait_idle();
      configure(16'h7FFF, 16'h8000, 3'd2, 7'd0, 1'b0, 16'h8000, 16'h8001, 11'd0);
      run_plane(8, 10);
      wait_idle();
   endtask

   // hold results back long enough that the block stalls its input
   task automatic test_backpressure();
      configure(16'hC000, 16'h4000, 3'd1, 7'd4, 1'b0, 16'h8000, 16'h8001, 11'd4);
      hold_left = 400;
      run_plane(40, 5);
      wait_idle();
   endtask

   task automatic test_random_planes();
      int w, n, plane_no;
      logic [15:0] a, b;
      plane_no = 0;
      while (items_sent < ITEMS) begin
         a = 16'($urandom_range(16'hFFFF));
         b = 16'($urandom_range(16'hFFFF));
         if ($urandom_range(3) != 0 && $signed(a) > $signed(b)) {a, b} = {b, a};
         w = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         configure(a, b, 3'($urandom_range(4)), ($urandom_range(7) == 0) ?
                   7'($urandom_range(127)) : 7'($urandom_range(10)),
                   1'($urandom_range(1)),
                   $urandom_range(1) ? 16'($urandom_range(16'hFFFF)) : a,
                   16'($urandom_range(16'hFFFF)), 11'(w));
         quiet = (plane_no % 8) == 3;
         n = (w > 8) ? $urandom_range(1, 2 * w + 5) : $urandom_range(1, 6 * w + 3);
         run_plane(n, $urandom_range(25));
         wait_idle();
         plane_no++;
      end
      quiet = 1'b0;
   endtask

   initial begin
      model_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_codes_and_override();
      test_stray_items();
      test_clamped_sizes();
      test_backpressure();
      test_random_planes();
      wait_idle();
      if (mismatches == 0 && class_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // hard stop if the run hangs
   initial begin
      #40000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/wtc_pkg.sv
rtl/wtc_ram.sv
rtl/wtc_ctrl.sv
rtl/wtc_datapath.sv
rtl/window_threshold_classifier_top.sv
rtl/wtc_checker.sv
tb/tb.sv
